>>> hw/rtl/spf_pkg.sv
// Shared types and constants of the smallest-prime-factor sieve and factorizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    // Fixed field widths of the command, result and configuration transfers
    localparam int VALUE_W  = 17;
    localparam int COUNT_W  = 14;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 17;

    // Default sizes of the table and of the prime list
    localparam int DEF_MAX_LIMIT  = 65536;
    localparam int DEF_MAX_PRIMES = 8192;

    // Smallest usable limit, reset limit and the cap on results per query
    localparam int              MIN_LIMIT  = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;
    localparam int              RESULT_CAP = 16;

    // Command codes
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  factor;
        logic [COUNT_W-1:0]  prime_count;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_res_item;

endpackage

`default_nettype wire

>>> hw/rtl/spf_sieve.sv
// Linear sieve sequencer: clears the table, fills smallest factors and cofactors,
// and keeps the prime list in its own memory. Depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spf_sieve #(
    parameter int MAX_LIMIT  = spf_pkg::DEF_MAX_LIMIT,
    parameter int MAX_PRIMES = spf_pkg::DEF_MAX_PRIMES,
    localparam int AW = $clog2(MAX_LIMIT + 1),
    localparam int CW = $clog2(MAX_PRIMES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_limit,
    output logic               o_busy,
    output logic               o_done,
    output logic [CW-1:0]      o_count,
    output logic [AW-1:0]      o_limit,
    output logic               o_tbl_we,
    output logic [AW-1:0]      o_tbl_waddr,
    output logic [AW-1:0]      o_tbl_wspf,
    output logic [AW-1:0]      o_tbl_wcof,
    output logic               o_tbl_re,
    output logic [AW-1:0]      o_tbl_raddr,
    input  wire logic [AW-1:0] i_tbl_rspf
);
    import spf_pkg::*;

    localparam int PW = $clog2(MAX_PRIMES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_RD_I  = 3'd2;
    localparam logic [2:0] S_CHK_I = 3'd3;
    localparam logic [2:0] S_RD_P  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_NEXT  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_lim, n_lim;
    logic [AW-1:0]   r_spf_i, n_spf_i;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_p;
    logic [2*AW-1:0] r_prod;
    logic            w_pl_we;
    logic            w_pl_re;

    // Prime list memory
    logic [AW-1:0] r_plist [MAX_PRIMES];
    logic [AW-1:0] r_prd;

    // Sequence clear, number visit and prime steps
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_lim       = r_lim;
        n_spf_i     = r_spf_i;
        n_j         = r_j;
        n_count     = r_count;
        o_tbl_we    = 1'b0;
        o_tbl_waddr = r_i;
        o_tbl_wspf  = '0;
        o_tbl_wcof  = '0;
        o_tbl_re    = 1'b0;
        o_tbl_raddr = r_i;
        w_pl_we     = 1'b0;
        w_pl_re     = 1'b0;
        o_done      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CLR;
                    n_i     = '0;
                    n_lim   = i_limit;
                    n_count = '0;
                end
            end
            S_CLR: begin
                o_tbl_we = 1'b1;
                if (r_i == r_lim) begin
                    n_i     = AW'(MIN_LIMIT);
                    n_state = S_RD_I;
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            S_RD_I: begin
                o_tbl_re = 1'b1;
                n_state  = S_CHK_I;
            end
            S_CHK_I: begin
                n_j     = '0;
                n_state = S_RD_P;
                if (i_tbl_rspf == '0) begin
                    // Untouched entry: i is prime
                    o_tbl_we   = 1'b1;
                    o_tbl_wspf = r_i;
                    o_tbl_wcof = AW'(1);
                    n_spf_i    = r_i;
                    if (r_count != CW'(MAX_PRIMES)) begin
                        w_pl_we = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    n_spf_i = i_tbl_rspf;
                end
            end
            S_RD_P: begin
                if (r_j == r_count) begin
                    n_state = S_NEXT;
                end else begin
                    w_pl_re = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (r_p > r_spf_i || r_prod > {{AW{1'b0}}, r_lim}) begin
                    n_state = S_NEXT;
                end else begin
                    o_tbl_we    = 1'b1;
                    o_tbl_waddr = r_prod[AW-1:0];
                    o_tbl_wspf  = r_p;
                    o_tbl_wcof  = r_i;
                    n_j         = r_j + CW'(1);
                    n_state     = S_RD_P;
                end
            end
            S_NEXT: begin
                if (r_i == r_lim) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_RD_I;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_i     <= n_i;
        r_lim   <= n_lim;
        r_spf_i <= n_spf_i;
        r_j     <= n_j;
    end

    // Register the prime and the product i * p
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_p    <= r_prd;
            r_prod <= {{AW{1'b0}}, r_i} * {{AW{1'b0}}, r_prd};
        end
    end

    // Prime list: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_pl_we) begin
            r_plist[r_count[PW-1:0]] <= r_i;
        end
        if (w_pl_re) begin
            r_prd <= r_plist[r_j[PW-1:0]];
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_count = r_count;
    assign o_limit = r_lim;

endmodule

`default_nettype wire

>>> hw/rtl/spf_factor.sv
// Factor walker: follows smallest-factor and cofactor entries of the table and
// emits one result per prime factor, up to RESULT_CAP results. Depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spf_factor #(
    parameter int MAX_LIMIT = spf_pkg::DEF_MAX_LIMIT,
    localparam int AW = $clog2(MAX_LIMIT + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_value,
    output logic               o_busy,
    output logic               o_tbl_re,
    output logic [AW-1:0]      o_tbl_raddr,
    input  wire logic [AW-1:0] i_tbl_rspf,
    input  wire logic [AW-1:0] i_tbl_rcof,
    output logic               o_res_valid,
    output spf_pkg::t_res_item o_res
);
    import spf_pkg::*;

    localparam int KW = $clog2(RESULT_CAP);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RD   = 2'd1;
    localparam logic [1:0] F_USE  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_n, n_n;
    logic [KW-1:0] r_k, n_k;
    logic          w_bad;
    logic [AW-1:0] w_c;
    logic [AW-1:0] w_q;
    logic          w_last;

    // Take an entry as the remaining value itself when it cannot be a factor
    assign w_bad  = (i_tbl_rspf < AW'(MIN_LIMIT)) || (i_tbl_rspf > r_n);
    assign w_c    = w_bad ? r_n : i_tbl_rspf;
    assign w_q    = w_bad ? AW'(1) : i_tbl_rcof;
    assign w_last = (w_q <= AW'(1)) || (r_k == KW'(RESULT_CAP - 1));

    // Alternate lookup and emit
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        o_tbl_re    = 1'b0;
        o_tbl_raddr = r_n;
        o_res_valid = 1'b0;
        o_res       = '{VALUE_W'(w_c), COUNT_W'(0), ST_OK, w_last};
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_n     = i_value;
                    n_k     = '0;
                    n_state = F_RD;
                end
            end
            F_RD: begin
                o_tbl_re = 1'b1;
                n_state  = F_USE;
            end
            F_USE: begin
                o_res_valid = 1'b1;
                n_n         = w_q;
                n_k         = r_k + KW'(1);
                n_state     = w_last ? F_IDLE : F_RD;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n <= n_n;
        r_k <= n_k;
    end

    assign o_busy = (r_state != F_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/spf_sieve_factorizer.sv
// Top level: command dispatch, the smallest-factor table memory, limit register
// and result register. Depends on spf_pkg, spf_sieve and spf_factor.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low; results come out as
// one-cycle strobes on o_res_strobe and cannot be held off, so the receiver must
// take every strobed result. A build with limit L (the configured limit clamped
// to 2..MAX_LIMIT) first clears table entries 0..L, one per cycle. It then
// visits each number 2..L with a table read, a check, the closing step of the
// prime loop and the advance, plus a prime read, a multiply and a write for
// each table write of the linear sieve, and the build answers with one result
// carrying the prime count. A query answered at once (table not built, value
// above the built limit, value 0 or 1) gives its result the cycle after the
// transfer; a factored query alternates a table read and an emit per prime
// factor, its first result strobing after the walker's read state, the table
// read register and the result register, at most 16 results. Each table entry
// holds the smallest prime factor and the cofactor, so no divider is needed.
// Write the limit only while busy is low.
module spf_sieve_factorizer #(
    parameter int MAX_LIMIT  = spf_pkg::DEF_MAX_LIMIT,
    parameter int MAX_PRIMES = spf_pkg::DEF_MAX_PRIMES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire spf_pkg::t_cmd_item          i_cmd,
    input  wire logic                        i_cfg_we,
    input  wire logic [spf_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                             o_res_strobe,
    output spf_pkg::t_res_item               o_res
);
    import spf_pkg::*;

    localparam int AW   = $clog2(MAX_LIMIT + 1);
    localparam int CW   = $clog2(MAX_PRIMES + 1);
    localparam int CMPW = (AW > VALUE_W) ? AW : VALUE_W;

    logic [CFG_W-1:0] r_cfg_limit;
    logic             r_built;
    logic [AW-1:0]    r_built_lim;
    logic             r_res_valid, n_res_valid;
    t_res_item        r_res, n_res;

    logic [CMPW-1:0]  w_cfg_ext;
    logic [AW-1:0]    w_limit;
    logic [CMPW-1:0]  w_val_ext;
    logic             w_accept;
    logic             w_sv_start;
    logic             w_fa_start;

    logic             sv_busy, sv_done, sv_we, sv_re;
    logic [CW-1:0]    sv_count;
    logic [AW-1:0]    sv_limit, sv_waddr, sv_wspf, sv_wcof, sv_raddr;
    logic             fa_busy, fa_re, fa_valid;
    logic [AW-1:0]    fa_raddr;
    t_res_item        fa_res;

    // Smallest-factor table: {spf, cofactor} per entry
    logic [2*AW-1:0]  r_tbl [0:MAX_LIMIT];
    logic [2*AW-1:0]  r_tbl_rd;
    logic [AW-1:0]    w_raddr;

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg_limit <= i_cfg_data;
        end
    end

    // Clamp the limit to the table range
    assign w_cfg_ext = CMPW'(r_cfg_limit);
    always_comb begin
        if (w_cfg_ext < CMPW'(MIN_LIMIT)) begin
            w_limit = AW'(MIN_LIMIT);
        end else if (w_cfg_ext > CMPW'(MAX_LIMIT)) begin
            w_limit = AW'(MAX_LIMIT);
        end else begin
            w_limit = AW'(w_cfg_ext);
        end
    end

    assign busy      = sv_busy || fa_busy;
    assign w_accept  = start && !busy;
    assign w_val_ext = CMPW'(i_cmd.value);

    // Dispatch a transfer and pick the result source
    always_comb begin
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_sv_start  = 1'b0;
        w_fa_start  = 1'b0;
        if (w_accept) begin
            if (i_cmd.command == CMD_BUILD) begin
                w_sv_start = 1'b1;
            end else if (!r_built) begin
                n_res_valid = 1'b1;
                n_res       = '{VALUE_W'(1), COUNT_W'(0), ST_NOT_BUILT, 1'b1};
            end else if (w_val_ext > CMPW'(r_built_lim)) begin
                n_res_valid = 1'b1;
                n_res       = '{VALUE_W'(1), COUNT_W'(0), ST_RANGE, 1'b1};
            end else if (i_cmd.value <= VALUE_W'(1)) begin
                n_res_valid = 1'b1;
                n_res       = '{VALUE_W'(1), COUNT_W'(0), ST_OK, 1'b1};
            end else begin
                w_fa_start = 1'b1;
            end
        end else if (sv_done) begin
            n_res_valid = 1'b1;
            n_res       = '{VALUE_W'(1), COUNT_W'(sv_count), ST_OK, 1'b1};
        end else if (fa_valid) begin
            n_res_valid = 1'b1;
            n_res       = fa_res;
        end
    end

    // Result register and built flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_built     <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            if (sv_done) begin
                r_built <= 1'b1;
            end
        end
        if (n_res_valid) begin
            r_res <= n_res;
        end
        if (sv_done) begin
            r_built_lim <= sv_limit;
        end
    end

    // Table memory: sieve writes, either unit reads
    assign w_raddr = sv_re ? sv_raddr : fa_raddr;
    always_ff @(posedge i_clk) begin
        if (sv_we) begin
            r_tbl[sv_waddr] <= {sv_wspf, sv_wcof};
        end
        if (sv_re || fa_re) begin
            r_tbl_rd <= r_tbl[w_raddr];
        end
    end

    spf_sieve #(
        .MAX_LIMIT  (MAX_LIMIT),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_sieve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sv_start),
        .i_limit     (w_limit),
        .o_busy      (sv_busy),
        .o_done      (sv_done),
        .o_count     (sv_count),
        .o_limit     (sv_limit),
        .o_tbl_we    (sv_we),
        .o_tbl_waddr (sv_waddr),
        .o_tbl_wspf  (sv_wspf),
        .o_tbl_wcof  (sv_wcof),
        .o_tbl_re    (sv_re),
        .o_tbl_raddr (sv_raddr),
        .i_tbl_rspf  (r_tbl_rd[2*AW-1:AW])
    );

    spf_factor #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_factor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_fa_start),
        .i_value     (AW'(i_cmd.value)),
        .o_busy      (fa_busy),
        .o_tbl_re    (fa_re),
        .o_tbl_raddr (fa_raddr),
        .i_tbl_rspf  (r_tbl_rd[2*AW-1:AW]),
        .i_tbl_rcof  (r_tbl_rd[AW-1:0]),
        .o_res_valid (fa_valid),
        .o_res       (fa_res)
    );

    assign o_res_strobe = r_res_valid;
    assign o_res        = r_res;

    // A result only follows a transfer or work in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> ($past(busy) || $past(start)))
        else $error("result strobe without a command in flight");

    // Sieve and walker never share the table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sv_busy && fa_busy))
        else $error("sieve and factor walker active together");

    // The final result of a command leaves the block idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.last) |-> !busy)
        else $error("busy after last result");

    // A result that is not final means more work is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.last) |-> busy)
        else $error("idle before last result");

    // Finishing a build marks the table as built
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sv_done |=> r_built)
        else $error("table not marked built after build");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the smallest-prime-factor sieve and factorizer.
// Drives builds and queries, checks results via a local sieve or table; uses spf_pkg.
`timescale 1ns / 1ps

module tb_top;
    import spf_pkg::*;

    localparam int TABLE_MAX  = DEF_MAX_LIMIT;
    localparam int PRIME_MAX  = DEF_MAX_PRIMES;
    localparam int RAND_ITEMS = 194;
    localparam int VALUE_MAX  = (1 << VALUE_W) - 1;

    // One row of the directed table; res is used only when fixed is set
    typedef struct packed {
        bit               load_limit;
        logic [CFG_W-1:0] limit;
        t_cmd_item        cmd;
        bit               fixed;
        t_res_item        res;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_cmd_item        i_cmd;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_res_strobe;
    t_res_item        o_res;

    // Local copy of the factor table, prime list and limits
    int unsigned spf_mem [0:TABLE_MAX];
    int unsigned primes [0:PRIME_MAX-1];
    int unsigned n_primes;
    int unsigned limit_reg;
    int unsigned limit_used;
    bit          sieved;

    t_res_item   factor_q[$];
    t_stim_row   rows[$];
    int          errors;

    spf_sieve_factorizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_res_item pack_res(int unsigned f, int unsigned cnt,
                                           logic [STATUS_W-1:0] st, bit last);
        t_res_item r;
        r.factor      = VALUE_W'(f);
        r.prime_count = COUNT_W'(cnt);
        r.status      = st;
        r.last        = last;
        return r;
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void queue_expected(t_res_item r);
        factor_q = {factor_q, r};
    endfunction

    // Linear sieve over 2..L with L the clamped configured limit
    function automatic void run_sieve();
        int unsigned lim;
        int unsigned i;
        int unsigned j;
        int unsigned p;
        lim = limit_reg;
        if (lim < MIN_LIMIT) lim = MIN_LIMIT;
        if (lim > TABLE_MAX) lim = TABLE_MAX;
        for (i = 0; i <= lim; i++) spf_mem[i] = 0;
        n_primes = 0;
        for (i = 2; i <= lim; i++) begin
            if (spf_mem[i] == 0) begin
                spf_mem[i] = i;
                if (n_primes < PRIME_MAX) begin
                    primes[n_primes] = i;
                    n_primes++;
                end
            end
            for (j = 0; j < n_primes; j++) begin
                p = primes[j];
                if (p > spf_mem[i] || longint'(i) * longint'(p) > longint'(lim)) break;
                spf_mem[i * p] = p;
            end
        end
        limit_used = lim;
        sieved     = 1'b1;
    endfunction

    // Work out every result of one accepted command and queue them
    function automatic void factorize_cmd(t_cmd_item c);
        int unsigned n;
        int unsigned fct;
        int          k;
        if (c.command == CMD_BUILD) begin
            run_sieve();
            queue_expected(pack_res(1, n_primes, ST_OK, 1'b1));
        end else if (!sieved) begin
            queue_expected(pack_res(1, 0, ST_NOT_BUILT, 1'b1));
        end else if (c.value > limit_used) begin
            queue_expected(pack_res(1, 0, ST_RANGE, 1'b1));
        end else if (c.value <= 1) begin
            queue_expected(pack_res(1, 0, ST_OK, 1'b1));
        end else begin
            n = c.value;
            k = 0;
            while (n > 1 && k < RESULT_CAP) begin
                fct = spf_mem[n];
                if (fct < 2 || fct > n) fct = n;
                n = n / fct;
                queue_expected(pack_res(fct, 0, ST_OK, n <= 1 || k == RESULT_CAP - 1));
                k++;
            end
        end
    endfunction

    function automatic void add_row(bit ld, int unsigned lim, logic cmd, int unsigned val,
                                    bit fixed, int unsigned f, int unsigned cnt,
                                    logic [STATUS_W-1:0] st);
        t_stim_row r;
        r.load_limit  = ld;
        r.limit       = CFG_W'(lim);
        r.cmd.command = cmd;
        r.cmd.value   = VALUE_W'(val);
        r.fixed       = fixed;
        r.res         = pack_res(f, cnt, st, 1'b1);
        rows = {rows, r};
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(2000, 3000);
            default: return $urandom_range(3, 600);
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Present one command after a random gap and hold it until the transfer
    task automatic send(t_cmd_item c, bit fixed, t_res_item res);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (fixed) begin
            if (c.command == CMD_BUILD) run_sieve();
            queue_expected(res);
        end else begin
            factorize_cmd(c);
        end
        @(negedge i_clk);
    endtask

    // Drop start and wait until every result is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        while (factor_q.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        limit_reg  = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_res_item want;
        if (i_rst_n && o_res_strobe) begin
            if (factor_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result factor %0d count %0d status %0d",
                                        o_res.factor, o_res.prime_count, o_res.status));
            end else begin
                want = factor_q.pop_front();
                if (o_res.factor !== want.factor)
                    flag_mismatch($sformatf("factor %0d, want %0d",
                                            o_res.factor, want.factor));
                if (o_res.prime_count !== want.prime_count)
                    flag_mismatch($sformatf("prime_count %0d, want %0d",
                                            o_res.prime_count, want.prime_count));
                if (o_res.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_res.status, want.status));
                if (o_res.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", o_res.last, want.last));
            end
        end
    end

    initial begin
        t_cmd_item c;
        start      = 1'b0;
        i_cmd      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        n_primes   = 0;
        sieved     = 1'b0;
        limit_reg  = CFG_RESET;
        limit_used = 0;
        errors     = 0;

        // Queries before any build
        add_row(0, 0, CMD_QUERY, 5, 1, 1, 0, ST_NOT_BUILT);
        add_row(0, 0, CMD_QUERY, 0, 1, 1, 0, ST_NOT_BUILT);
        // Build at the reset limit; the value field is ignored
        add_row(0, 0, CMD_BUILD, VALUE_MAX, 1, 1, 6542, ST_OK);
        add_row(0, 0, CMD_QUERY, 0, 1, 1, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 1, 1, 1, 0, ST_OK);
        // Sixteen factors of two fill the result cap exactly
        add_row(0, 0, CMD_QUERY, 65536, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 65535, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 65521, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 2, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 30030, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 65537, 1, 1, 0, ST_RANGE);
        add_row(0, 0, CMD_QUERY, VALUE_MAX, 1, 1, 0, ST_RANGE);
        // A new limit stays pending until the next build
        add_row(1, 100, CMD_QUERY, 5000, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 65536, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_BUILD, 0, 1, 1, 25, ST_OK);
        add_row(0, 0, CMD_QUERY, 101, 1, 1, 0, ST_RANGE);
        add_row(0, 0, CMD_QUERY, 100, 0, 0, 0, ST_OK);
        // Limits below the minimum clamp to two
        add_row(1, 0, CMD_BUILD, 0, 1, 1, 1, ST_OK);
        add_row(0, 0, CMD_QUERY, 2, 1, 2, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 3, 1, 1, 0, ST_RANGE);
        add_row(1, 1, CMD_BUILD, 77, 1, 1, 1, ST_OK);
        add_row(1, 3, CMD_BUILD, 0, 1, 1, 2, ST_OK);
        add_row(0, 0, CMD_QUERY, 3, 0, 0, 0, ST_OK);
        // A limit above the table size clamps to the full table
        add_row(1, (1 << CFG_W) - 1, CMD_BUILD, 0, 1, 1, 6542, ST_OK);
        add_row(0, 0, CMD_QUERY, 65536, 0, 0, 0, ST_OK);
        add_row(0, 0, CMD_QUERY, 49152, 0, 0, 0, ST_OK);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (rows[i]) begin
            if (rows[i].load_limit) begin
                settle();
                write_limit(rows[i].limit);
            end
            send(rows[i].cmd, rows[i].fixed, rows[i].res);
        end

        // Random queries on the full table, then phases of small random tables
        for (int n = 0; n < RAND_ITEMS; n++) begin
            c.value = VALUE_W'($urandom_range(0, VALUE_MAX));
            if (n >= 60 && n % 20 == 0) begin
                settle();
                write_limit(CFG_W'(pick_limit()));
                c.command = CMD_BUILD;
            end else if (limit_reg <= 3000 && $urandom_range(0, 19) == 0) begin
                c.command = CMD_BUILD;
            end else begin
                c.command = CMD_QUERY;
                case ($urandom_range(0, 9))
                    7:       c.value = VALUE_W'($urandom_range(0, 1));
                    8:       c.value = VALUE_W'(limit_used + 1);
                    9:       c.value = VALUE_W'($urandom_range(0, VALUE_MAX));
                    default: c.value = VALUE_W'($urandom_range(0, limit_used));
                endcase
            end
            send(c, 1'b0, '0);
        end

        // Drain and let any stray strobe show up
        start <= 1'b0;
        while (factor_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
